@@ src/npm_pkg.sv @@
// Package for the name pattern matcher: widths, codes, cell control/status
// structs and the case-fold function. No dependencies.
package npm_pkg;

  localparam int unsigned PatternMaxDef = 32;
  localparam int unsigned CharW         = 16;
  localparam int unsigned PatIdxW       = 5;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 6;
  localparam int unsigned LenRegW       = 6;

  localparam logic [CharW-1:0] AsciiUpperA   = 16'h0041;
  localparam logic [CharW-1:0] AsciiUpperZ   = 16'h005A;
  localparam logic [CharW-1:0] Latin1UpperLo = 16'h00C0;
  localparam logic [CharW-1:0] Latin1UpperHi = 16'h00DE;
  localparam logic [CharW-1:0] Latin1Times   = 16'h00D7;
  localparam logic [CharW-1:0] CaseOffset    = 16'd32;

  typedef enum logic [1:0] {
    MODE_CONTAINS = 2'd0,
    MODE_PREFIX   = 2'd1,
    MODE_SUFFIX   = 2'd2,
    MODE_EXACT    = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH_MODE = 2'd0,
    CFG_CASE_SENS  = 2'd1,
    CFG_PAT_LEN    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NAME = 1'b1
  } op_e;

  // Broadcast from the control to every cell
  typedef struct packed {
    logic               load;
    logic [PatIdxW-1:0] idx;
    logic               step;
    logic               clear;
    logic [CharW-1:0]   ch;
  } npm_ctl_t;

  // Per-cell status back to the control
  typedef struct packed {
    logic tail_hit;
    logic pfx_miss;
  } npm_stat_t;

  // Lower-case fold: ASCII A-Z and Latin-1 capitals except the times sign
  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= AsciiUpperA && c <= AsciiUpperZ) begin
      r = c + CaseOffset;
    end else if (c >= Latin1UpperLo && c <= Latin1UpperHi && c != Latin1Times) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

@@ src/npm_cell.sv @@
// One comparator cell of the matcher chain: holds one pattern character, one
// partial-match bit and one position token. Depends on npm_pkg.
module npm_cell import npm_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned POS_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  npm_ctl_t         ctl_i,
  input  logic [POS_W-1:0] len_i,
  input  logic             prev_bit_i,
  input  logic             prev_tok_i,
  output logic             bit_o,
  output logic             tok_o,
  output npm_stat_t        stat_o
);

  localparam logic IsHead = (IDX == 0);

  logic [CharW-1:0] pat_q;
  logic             bit_q, bit_d;
  logic             tok_q, tok_d;
  logic             eq;
  logic             new_bit;
  logic             tail_hit;
  logic             pfx_miss;

  // Load the pattern character addressed to this cell
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && 32'(ctl_i.idx) == 32'(IDX)) begin
      pat_q <= ctl_i.ch;
    end
  end

  assign eq      = (ctl_i.ch == pat_q);
  assign new_bit = prev_bit_i && eq;

  // Advance the partial match and the token; reset both at end of name
  always_comb begin
    bit_d = bit_q;
    tok_d = tok_q;
    if (ctl_i.step) begin
      if (ctl_i.clear) begin
        bit_d = 1'b0;
        tok_d = IsHead;
      end else begin
        bit_d = new_bit;
        tok_d = prev_tok_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
      tok_q <= IsHead;
    end else begin
      bit_q <= bit_d;
      tok_q <= tok_d;
    end
  end

  // Tail cell reports a full match; token cell reports a prefix mismatch
  assign tail_hit = new_bit && (POS_W'(IDX + 1) == len_i);
  assign pfx_miss = tok_q && (POS_W'(IDX) < len_i) && !eq;
  assign stat_o   = {tail_hit, pfx_miss};

  assign bit_o = bit_q;
  assign tok_o = tok_q;

endmodule

@@ src/name_pattern_matcher_unit.sv @@
// Top level of the name pattern matcher: configuration, cell chain and
// result register. Depends on npm_pkg and npm_cell.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | operation, char_code,
//           |           |                         | pattern_index, last_char
//   out     | output    | out_valid_o/out_stall_i | matched
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One item per cycle unless the input stalls: every name character is compared
// in all cells at once, so the cell chain takes one character each clock.
// The result of a last character appears in the output register in the cycle
// after that character is accepted.
// Input stalls only while a result waits and the output side stalls.
// Reset clears the configuration, name tracking and output valid; the pattern
// is undefined until loaded.
module name_pattern_matcher_unit import npm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [CharW-1:0]    char_code_i,
  input  logic [PatIdxW-1:0]  pattern_index_i,
  input  logic                last_char_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                matched_o
);

  localparam int unsigned POS_W = $clog2(PATTERN_MAX + 2);
  localparam int unsigned CMP_W = (POS_W > LenRegW) ? POS_W : LenRegW;

  mode_e              mode_q;
  logic               case_sens_q;
  logic [LenRegW-1:0] pat_len_q;
  logic [POS_W-1:0]   len_eff;

  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic             prefix_ok_q, prefix_ok_d, prefix_new;
  logic             substr_q, substr_d, substr_new;
  logic             out_valid_q, out_valid_d;
  logic             matched_q, matched_d;
  logic             match;

  logic      in_acc, name_step, last_step;
  npm_ctl_t  ctl;
  npm_stat_t stat [PATTERN_MAX];
  logic      any_tail, any_miss;

  logic [PATTERN_MAX-2:0] bit_link;
  logic [PATTERN_MAX-2:0] tok_link;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CONTAINS;
      case_sens_q <= 1'b0;
      pat_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MATCH_MODE: mode_q      <= mode_e'(cfg_data_i[1:0]);
        CFG_CASE_SENS:  case_sens_q <= cfg_data_i[0];
        CFG_PAT_LEN:    pat_len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the length register to the chain length
  always_comb begin
    if (CMP_W'(pat_len_q) > CMP_W'(PATTERN_MAX)) begin
      len_eff = POS_W'(PATTERN_MAX);
    end else begin
      len_eff = POS_W'(pat_len_q);
    end
  end

  // Input handshake and cell broadcast
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign name_step  = in_acc && (op_e'(operation_i) == OP_NAME);
  assign last_step  = name_step && last_char_i;

  always_comb begin
    ctl.load  = in_acc && (op_e'(operation_i) == OP_LOAD);
    ctl.idx   = pattern_index_i;
    ctl.step  = name_step;
    ctl.clear = last_step;
    ctl.ch    = case_sens_q ? char_code_i : fold_char(char_code_i);
  end

  // Cell chain
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev_bit, prev_tok;
    if (k == 0) begin : g_head
      assign prev_bit = 1'b1;
      assign prev_tok = 1'b0;
    end else begin : g_body
      assign prev_bit = bit_link[k-1];
      assign prev_tok = tok_link[k-1];
    end
    if (k < PATTERN_MAX - 1) begin : g_mid
      npm_cell #(.IDX(k), .POS_W(POS_W)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .len_i      (len_eff),
        .prev_bit_i (prev_bit),
        .prev_tok_i (prev_tok),
        .bit_o      (bit_link[k]),
        .tok_o      (tok_link[k]),
        .stat_o     (stat[k])
      );
    end else begin : g_tail
      npm_cell #(.IDX(k), .POS_W(POS_W)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .len_i      (len_eff),
        .prev_bit_i (prev_bit),
        .prev_tok_i (prev_tok),
        .bit_o      (),
        .tok_o      (),
        .stat_o     (stat[k])
      );
    end
  end

  // Collect cell status
  always_comb begin
    any_tail = 1'b0;
    any_miss = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      any_tail = any_tail | stat[i].tail_hit;
      any_miss = any_miss | stat[i].pfx_miss;
    end
  end

  // Name tracking and verdict
  assign pos_inc    = (pos_q < POS_W'(PATTERN_MAX + 1)) ? pos_q + 1'b1 : pos_q;
  assign prefix_new = prefix_ok_q && !any_miss;
  assign substr_new = substr_q || any_tail;

  always_comb begin
    if (len_eff == '0) begin
      match = 1'b1;
    end else if (pos_inc < len_eff) begin
      match = 1'b0;
    end else begin
      case (mode_q)
        MODE_CONTAINS: match = substr_new;
        MODE_PREFIX:   match = prefix_new;
        MODE_SUFFIX:   match = any_tail;
        MODE_EXACT:    match = prefix_new && (pos_inc == len_eff);
        default:       match = 1'b0;
      endcase
    end
  end

  always_comb begin
    pos_d       = pos_q;
    prefix_ok_d = prefix_ok_q;
    substr_d    = substr_q;
    if (name_step) begin
      if (last_char_i) begin
        pos_d       = '0;
        prefix_ok_d = 1'b1;
        substr_d    = 1'b0;
      end else begin
        pos_d       = pos_inc;
        prefix_ok_d = prefix_new;
        substr_d    = substr_new;
      end
    end
  end

  // Hold a result until taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    matched_d   = matched_q;
    if (last_step) begin
      out_valid_d = 1'b1;
      matched_d   = match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      prefix_ok_q <= 1'b1;
      substr_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      prefix_ok_q <= prefix_ok_d;
      substr_q    <= substr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

@@ src/npm_checker.sv @@
// Port-level checks for the name pattern matcher, bound to the top level.
// Depends on npm_pkg and name_pattern_matcher_unit.
module npm_checker import npm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic operation_i,
  input logic last_char_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic matched_o
);

  logic last_acc;
  assign last_acc = in_valid_i && !in_stall_o && (op_e'(operation_i) == OP_NAME) &&
                    last_char_i;

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_o))
    else $error("stalled result changed");

  // A finished name gives a result in the next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> out_valid_o)
    else $error("missing result after last character");

  // A new result only follows a last name character
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(last_acc))
    else $error("result without a finished name");

  // Input stalls only behind a waiting result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

endmodule

bind name_pattern_matcher_unit npm_checker u_npm_checker (.*);
